// ===== rtl/jsrg_pkg.sv =====
// package with payload types, register codes and constants of the joystick step rate generator
package jsrg_pkg;

  localparam int AXES_DEF     = 3;
  localparam int ADC_FULL_DEF = 1023;
  localparam int OUT_AXES     = 3;
  localparam int SAMPLE_W     = 10;
  localparam int CENTER_W     = 10;
  localparam int DZ_W         = 9;
  localparam int AXIS_SEL_W   = 2;
  localparam int POS_W        = 32;

  localparam logic [CENTER_W-1:0] CENTER_SPLIT  = 10'd512;
  localparam logic [CENTER_W-1:0] CENTER_RST    = 10'd512;
  localparam logic [DZ_W-1:0]     DEAD_ZONE_RST = 9'd20;

  typedef enum logic [1:0] {
    REG_CENTER_X  = 2'd0,
    REG_CENTER_Y  = 2'd1,
    REG_CENTER_Z  = 2'd2,
    REG_DEAD_ZONE = 2'd3
  } jsrg_reg_t;

  typedef struct packed {
    logic [AXIS_SEL_W-1:0] sample_axis;
    logic [SAMPLE_W-1:0]   sample;
  } jsrg_in_t;

  typedef struct packed {
    logic [OUT_AXES-1:0]     step_mask;
    logic [OUT_AXES-1:0]     dir_mask;
    logic signed [POS_W-1:0] position_x;
    logic signed [POS_W-1:0] position_y;
    logic signed [POS_W-1:0] position_z;
  } jsrg_out_t;

  typedef struct packed {
    logic tick;
    logic load_sample;
    logic reload;
  } jsrg_lane_ctrl_t;

endpackage

// ===== rtl/jsrg_axis.sv =====
// one axis lane: rate from sample, accumulator, step and position
module jsrg_axis #(
  parameter int ADC_FULL = jsrg_pkg::ADC_FULL_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  jsrg_pkg::jsrg_lane_ctrl_t         ctrl,
  input  logic [jsrg_pkg::SAMPLE_W-1:0]     sample,
  input  logic [jsrg_pkg::CENTER_W-1:0]     center,
  input  logic [jsrg_pkg::DZ_W-1:0]         dead_zone,
  output logic                              step_nxt,
  output logic                              fwd_nxt,
  output logic signed [jsrg_pkg::POS_W-1:0] pos_nxt
);

  localparam int RANGE_W = $clog2(ADC_FULL + 1);
  localparam int MAG_W   = (RANGE_W > jsrg_pkg::SAMPLE_W) ? RANGE_W : jsrg_pkg::SAMPLE_W;
  localparam int CALC_W  = MAG_W + 2;
  localparam int ACC_W   = RANGE_W + 1;

  function automatic logic [RANGE_W-1:0] range_calc(
    input logic [jsrg_pkg::CENTER_W-1:0] c,
    input logic [jsrg_pkg::DZ_W-1:0]     d
  );
    logic signed [CALC_W-1:0] r;
    if (c < jsrg_pkg::CENTER_SPLIT) begin
      r = CALC_W'(c) - CALC_W'(d);
    end else begin
      r = CALC_W'(ADC_FULL) - CALC_W'(c) - CALC_W'(d);
    end
    return r[CALC_W-1] ? '0 : r[RANGE_W-1:0];
  endfunction

  logic [RANGE_W-1:0]              rate_r;
  logic                            fwd_r;
  logic signed [ACC_W-1:0]         acc_r;
  logic signed [jsrg_pkg::POS_W-1:0] pos_r;

  logic [RANGE_W-1:0]      range;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        mag_c;
  logic                    fwd_s;
  logic [RANGE_W-1:0]      rate_s;
  logic [RANGE_W-1:0]      rate_eff;
  logic signed [ACC_W-1:0] acc_sub;
  logic signed [ACC_W-1:0] acc_new;

  always_comb begin
    range = range_calc(center, dead_zone);
    if (sample < center) begin
      mag   = MAG_W'(center - sample);
      fwd_s = 1'b0;
    end else begin
      mag   = MAG_W'(sample - center);
      fwd_s = 1'b1;
    end
    mag_c    = (mag > MAG_W'(range)) ? MAG_W'(range) : mag;
    rate_s   = (mag_c < MAG_W'(dead_zone)) ? '0 : RANGE_W'(mag_c - MAG_W'(dead_zone));
    rate_eff = ctrl.load_sample ? rate_s : rate_r;
    fwd_nxt  = ctrl.load_sample ? fwd_s : fwd_r;
    acc_sub  = acc_r - $signed({1'b0, rate_eff});
    step_nxt = acc_sub[ACC_W-1];
    acc_new  = step_nxt ? acc_sub + $signed({1'b0, range}) : acc_sub;
    if (!step_nxt) begin
      pos_nxt = pos_r;
    end else if (fwd_nxt) begin
      pos_nxt = pos_r + 32'sd1;
    end else begin
      pos_nxt = pos_r - 32'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
      fwd_r  <= 1'b1;
      acc_r  <= $signed({1'b0, range_calc(jsrg_pkg::CENTER_RST, jsrg_pkg::DEAD_ZONE_RST)});
      pos_r  <= '0;
    end else if (ctrl.reload) begin
      rate_r <= '0;
      acc_r  <= $signed({1'b0, range});
    end else if (ctrl.tick) begin
      rate_r <= rate_eff;
      fwd_r  <= fwd_nxt;
      acc_r  <= acc_new;
      pos_r  <= pos_nxt;
    end
  end

endmodule

// ===== rtl/joystick_step_rate_generator.sv =====
// top level of the joystick step rate generator: config registers, input and result registers
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | in_data  (sample_axis, sample)
//  out     | out_valid/ out_ready | out_data (step_mask, dir_mask, position_*)
//  cfg     | psel penable pwrite  | paddr, pwdata, prdata (pready tied high)
//
// one request per cycle sustained while out_ready is high; a request waits in the input
// register, its result in the output register; per-axis add and compare runs between.
// rst_n is synchronous; after reset the axes are loaded with the range of the reset config.
// a stalled result holds in the output register while one more request waits in the input
// register; in_ready drops only when both are full.
module joystick_step_rate_generator #(
  parameter int AXES     = jsrg_pkg::AXES_DEF,
  parameter int ADC_FULL = jsrg_pkg::ADC_FULL_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jsrg_pkg::jsrg_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output jsrg_pkg::jsrg_out_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NCFG = jsrg_pkg::OUT_AXES;

  logic [jsrg_pkg::CENTER_W-1:0] center_r   [NCFG];
  logic [jsrg_pkg::CENTER_W-1:0] center_nxt [NCFG];
  logic [jsrg_pkg::DZ_W-1:0]     dz_r;
  logic [jsrg_pkg::DZ_W-1:0]     dz_nxt;

  logic               in_valid_r;
  jsrg_pkg::jsrg_in_t  in_data_r;
  logic               out_valid_r;
  jsrg_pkg::jsrg_out_t out_data_r;
  jsrg_pkg::jsrg_out_t result;

  logic               wr;
  jsrg_pkg::jsrg_reg_t idx;
  logic               advance;

  logic                              step_w [AXES];
  logic                              fwd_w  [AXES];
  logic signed [jsrg_pkg::POS_W-1:0] pos_w  [AXES];

  logic [jsrg_pkg::OUT_AXES-1:0]     step_vec;
  logic [jsrg_pkg::OUT_AXES-1:0]     dir_vec;
  logic signed [jsrg_pkg::POS_W-1:0] pos_vec [jsrg_pkg::OUT_AXES];

  // config port
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = jsrg_pkg::jsrg_reg_t'(paddr[3:2]);

  always_comb begin
    for (int i = 0; i < NCFG; i++) begin
      center_nxt[i] = center_r[i];
    end
    dz_nxt = dz_r;
    if (wr) begin
      unique case (idx)
        jsrg_pkg::REG_CENTER_X:  center_nxt[0] = pwdata[jsrg_pkg::CENTER_W-1:0];
        jsrg_pkg::REG_CENTER_Y:  center_nxt[1] = pwdata[jsrg_pkg::CENTER_W-1:0];
        jsrg_pkg::REG_CENTER_Z:  center_nxt[2] = pwdata[jsrg_pkg::CENTER_W-1:0];
        jsrg_pkg::REG_DEAD_ZONE: dz_nxt        = pwdata[jsrg_pkg::DZ_W-1:0];
        default:                 dz_nxt        = dz_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      jsrg_pkg::REG_CENTER_X:  prdata = 32'(center_r[0]);
      jsrg_pkg::REG_CENTER_Y:  prdata = 32'(center_r[1]);
      jsrg_pkg::REG_CENTER_Z:  prdata = 32'(center_r[2]);
      jsrg_pkg::REG_DEAD_ZONE: prdata = 32'(dz_r);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCFG; i++) begin
        center_r[i] <= jsrg_pkg::CENTER_RST;
      end
      dz_r <= jsrg_pkg::DEAD_ZONE_RST;
    end else begin
      for (int i = 0; i < NCFG; i++) begin
        center_r[i] <= center_nxt[i];
      end
      dz_r <= dz_nxt;
    end
  end

  // input and result registers
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  // axis lanes
  for (genvar i = 0; i < AXES; i++) begin : g_lane
    jsrg_pkg::jsrg_lane_ctrl_t     ctrl;
    logic [jsrg_pkg::CENTER_W-1:0] lane_center;

    if (i < NCFG) begin : g_cfg
      assign lane_center = center_nxt[i];
      assign ctrl.reload = wr && (idx == jsrg_pkg::REG_DEAD_ZONE ||
                                  idx == jsrg_pkg::jsrg_reg_t'(i));
    end else begin : g_fixed
      assign lane_center = jsrg_pkg::CENTER_SPLIT;
      assign ctrl.reload = wr && (idx == jsrg_pkg::REG_DEAD_ZONE);
    end

    assign ctrl.tick        = advance;
    assign ctrl.load_sample = advance && (32'(in_data_r.sample_axis) == i);

    jsrg_axis #(
      .ADC_FULL (ADC_FULL)
    ) u_axis (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .sample    (in_data_r.sample),
      .center    (lane_center),
      .dead_zone (dz_nxt),
      .step_nxt  (step_w[i]),
      .fwd_nxt   (fwd_w[i]),
      .pos_nxt   (pos_w[i])
    );
  end

  for (genvar i = 0; i < jsrg_pkg::OUT_AXES; i++) begin : g_out
    if (i < AXES) begin : g_on
      assign step_vec[i] = step_w[i];
      assign dir_vec[i]  = fwd_w[i];
      assign pos_vec[i]  = pos_w[i];
    end else begin : g_off
      assign step_vec[i] = 1'b0;
      assign dir_vec[i]  = 1'b0;
      assign pos_vec[i]  = '0;
    end
  end

  always_comb begin
    result.step_mask  = step_vec;
    result.dir_mask   = dir_vec;
    result.position_x = pos_vec[0];
    result.position_y = pos_vec[1];
    result.position_z = pos_vec[2];
  end

  // checks
  a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input not ready while result register empty");

  a_advance_out : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("request moved on but no result shown");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && in_valid_r) |-> !in_ready)
    else $error("pending request could be overwritten");

  a_hold_pending : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> (in_valid_r && $stable(in_data_r)))
    else $error("stalled request lost from input register");

endmodule
